/* sv/hdt_pkg.sv */
// ----------------------------------------------------------------------------
// hdt_pkg: shared types and helpers for the hex dump text parser
// Holds the phase and command types, the result kind codes and the
// character classification functions used by the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package hdt_pkg;

  // sizes
  localparam int GROUP_DIGITS = 16;
  localparam int TOTAL_WIDTH  = 48;
  localparam int DIGIT_W      = 5;
  localparam int LEN_W        = 4;
  localparam int BYTE_IDX_W   = 3;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 5'd31;
  localparam logic [DIGIT_W-1:0] DIGIT_ADDR  = 5'd2;
  localparam logic [DIGIT_W-1:0] DIGIT_GROUP = DIGIT_W'(GROUP_DIGITS);

  // result kind codes
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_SEEK    = 2'd1;
  localparam logic [1:0] KIND_END_OK  = 2'd2;
  localparam logic [1:0] KIND_END_BAD = 2'd3;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // line parser phase
  typedef enum logic [2:0] {
    PH_LINE,
    PH_FIRST,
    PH_ADDR_SKIP,
    PH_GROUP,
    PH_AFTER_SEP,
    PH_IGNORE,
    PH_ENDED
  } phase_t;

  // end item request carried by a command
  typedef enum logic [1:0] {
    END_NONE,
    END_OK,
    END_BAD
  } end_t;

  // one queued command: data bytes, a seek, then an optional end item
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             seek;
    end_t             endk;
    logic [63:0]      value;
  } cmd_t;

  function automatic logic is_hex(logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else v = c - 8'h37;
    hex_val = v[3:0];
  endfunction

  function automatic logic is_space(logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

/* sv/hdt_if.sv */
// ----------------------------------------------------------------------------
// hdt_in_if / hdt_out_if: character and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface hdt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

/* sv/hdt_front.sv */
// ----------------------------------------------------------------------------
// hdt_front: character front end
// Runs the line parser one character per beat and turns each character
// into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hdt_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  hdt_in_if.sink              in_ch,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata,
  input  wire logic           q_full,
  output      logic           q_push,
  output      hdt_pkg::cmd_t  q_cmd
);

  hdt_pkg::phase_t                  phase_r, phase_nxt;
  logic [63:0]                      token_r, token_nxt;
  logic [hdt_pkg::DIGIT_W-1:0]      digit_cnt_r, digit_cnt_nxt;
  logic                             use_addr_r;

  logic                             fire;
  logic                             hex;
  logic                             space;
  logic                             addr_tok;
  logic [hdt_pkg::DIGIT_W-1:0]      dig;
  logic [63:0]                      mask;
  logic [63:0]                      token_masked;
  logic [hdt_pkg::LEN_W:0]          len_wide;
  hdt_pkg::cmd_t                    cmd;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign hex         = hdt_pkg::is_hex(in_ch.ch);
  assign space       = hdt_pkg::is_space(in_ch.ch);
  assign addr_tok    = digit_cnt_r > hdt_pkg::DIGIT_ADDR;

  // keep only the last group digits and size the byte run
  always_comb begin
    dig = (digit_cnt_r < hdt_pkg::DIGIT_GROUP) ? digit_cnt_r : hdt_pkg::DIGIT_GROUP;
    for (int k = 0; k < 16; k++) begin
      mask[4*k +: 4] = (hdt_pkg::DIGIT_W'(k) < dig) ? 4'hf : 4'h0;
    end
    token_masked = token_r & mask;
    len_wide     = (hdt_pkg::LEN_W+1)'((dig + hdt_pkg::DIGIT_W'(1)) >> 1);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_ch.end_of_input) begin
      phase_nxt = hdt_pkg::PH_ENDED;
    end else begin
      unique case (phase_r)
        hdt_pkg::PH_LINE: begin
          phase_nxt = hex ? hdt_pkg::PH_FIRST : hdt_pkg::PH_ENDED;
        end
        hdt_pkg::PH_FIRST: begin
          if (hex) phase_nxt = hdt_pkg::PH_FIRST;
          else if (in_ch.ch == hdt_pkg::CH_NL) phase_nxt = hdt_pkg::PH_LINE;
          else if (space || in_ch.ch == hdt_pkg::CH_DASH)
            phase_nxt = addr_tok ? hdt_pkg::PH_ADDR_SKIP : hdt_pkg::PH_AFTER_SEP;
          else phase_nxt = hdt_pkg::PH_IGNORE;
        end
        hdt_pkg::PH_ADDR_SKIP: begin
          if (in_ch.ch == hdt_pkg::CH_NL) phase_nxt = hdt_pkg::PH_LINE;
          else if (space) phase_nxt = hdt_pkg::PH_ADDR_SKIP;
          else if (hex) phase_nxt = hdt_pkg::PH_GROUP;
          else phase_nxt = hdt_pkg::PH_IGNORE;
        end
        hdt_pkg::PH_GROUP: begin
          if (hex) phase_nxt = hdt_pkg::PH_GROUP;
          else if (in_ch.ch == hdt_pkg::CH_NL) phase_nxt = hdt_pkg::PH_LINE;
          else if (space || in_ch.ch == hdt_pkg::CH_DASH) phase_nxt = hdt_pkg::PH_AFTER_SEP;
          else phase_nxt = hdt_pkg::PH_IGNORE;
        end
        hdt_pkg::PH_AFTER_SEP: begin
          if (hex) phase_nxt = hdt_pkg::PH_GROUP;
          else if (in_ch.ch == hdt_pkg::CH_NL) phase_nxt = hdt_pkg::PH_LINE;
          else phase_nxt = hdt_pkg::PH_IGNORE;
        end
        hdt_pkg::PH_IGNORE: begin
          if (in_ch.ch == hdt_pkg::CH_NL) phase_nxt = hdt_pkg::PH_LINE;
        end
        hdt_pkg::PH_ENDED: begin
          phase_nxt = hdt_pkg::PH_ENDED;
        end
        default: phase_nxt = hdt_pkg::PH_LINE;
      endcase
    end
    if (phase_r == hdt_pkg::PH_ENDED) phase_nxt = hdt_pkg::PH_ENDED;
  end

  // token accumulation
  always_comb begin
    token_nxt     = token_r;
    digit_cnt_nxt = digit_cnt_r;
    if (!in_ch.end_of_input && hex) begin
      unique case (phase_r)
        hdt_pkg::PH_LINE, hdt_pkg::PH_ADDR_SKIP, hdt_pkg::PH_AFTER_SEP: begin
          token_nxt     = {60'd0, hdt_pkg::hex_val(in_ch.ch)};
          digit_cnt_nxt = hdt_pkg::DIGIT_W'(1);
        end
        hdt_pkg::PH_FIRST, hdt_pkg::PH_GROUP: begin
          token_nxt = {token_r[59:0], hdt_pkg::hex_val(in_ch.ch)};
          if (digit_cnt_r < hdt_pkg::DIGIT_MAX)
            digit_cnt_nxt = digit_cnt_r + hdt_pkg::DIGIT_W'(1);
        end
        default: begin
          token_nxt     = token_r;
          digit_cnt_nxt = digit_cnt_r;
        end
      endcase
    end
  end

  // command toward the back end
  always_comb begin
    cmd.len   = '0;
    cmd.seek  = 1'b0;
    cmd.endk  = hdt_pkg::END_NONE;
    cmd.value = token_r;
    if (phase_r != hdt_pkg::PH_ENDED) begin
      if (in_ch.end_of_input) begin
        cmd.endk = hdt_pkg::END_OK;
        if (phase_r == hdt_pkg::PH_FIRST) begin
          if (addr_tok) cmd.seek = use_addr_r;
          else cmd.len = len_wide[hdt_pkg::LEN_W-1:0];
        end else if (phase_r == hdt_pkg::PH_GROUP) begin
          cmd.len = len_wide[hdt_pkg::LEN_W-1:0];
        end
      end else if (!hex) begin
        if (phase_r == hdt_pkg::PH_LINE) begin
          cmd.endk = hdt_pkg::END_BAD;
        end else if (phase_r == hdt_pkg::PH_FIRST) begin
          if (addr_tok) cmd.seek = use_addr_r;
          else cmd.len = len_wide[hdt_pkg::LEN_W-1:0];
        end else if (phase_r == hdt_pkg::PH_GROUP) begin
          cmd.len = len_wide[hdt_pkg::LEN_W-1:0];
        end
      end
    end
    if (cmd.len != '0) cmd.value = token_masked;
  end

  assign q_cmd  = cmd;
  assign q_push = fire && (cmd.len != '0 || cmd.seek || cmd.endk != hdt_pkg::END_NONE);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hdt_pkg::PH_LINE;
      token_r     <= '0;
      digit_cnt_r <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      token_r     <= token_nxt;
      digit_cnt_r <= digit_cnt_nxt;
    end
  end

  // address option register
  always_ff @(posedge clk) begin
    if (!rst_n) use_addr_r <= 1'b0;
    else if (cfg_we) use_addr_r <= cfg_wdata;
  end

endmodule

`default_nettype wire

/* sv/hdt_queue.sv */
// ----------------------------------------------------------------------------
// hdt_queue: command queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hdt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hdt_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output      hdt_pkg::cmd_t  head,
  output      logic           full,
  output      logic           empty
);

  hdt_pkg::cmd_t                   mem_r [hdt_pkg::QDEPTH];
  logic [hdt_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [hdt_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [hdt_pkg::QCNT_W-1:0]      count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full    = count_r == hdt_pkg::QCNT_W'(hdt_pkg::QDEPTH);
  assign empty   = count_r == '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + hdt_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + hdt_pkg::QPTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + hdt_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - hdt_pkg::QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/hdt_back.sv */
// ----------------------------------------------------------------------------
// hdt_back: result back end
// Expands one command into data bytes, a seek and an end item, one beat per
// cycle unless stalled, keeps the byte total and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hdt_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire hdt_pkg::cmd_t  head,
  input  wire logic           empty,
  output      logic           pop,
  hdt_out_if.source           out_ch
);

  logic [hdt_pkg::LEN_W-1:0]       cnt_r;
  logic                            seek_r;
  hdt_pkg::end_t                   endk_r;
  logic [63:0]                     val_r;
  logic [hdt_pkg::TOTAL_WIDTH-1:0] total_r;
  logic                            out_valid_r;
  logic [1:0]                      out_kind_r;
  logic [63:0]                     out_value_r;
  logic                            out_last_r;

  logic                            busy;
  logic                            emit_ok;
  logic                            item_last;
  logic [1:0]                      item_kind;
  logic [63:0]                     item_value;
  logic [hdt_pkg::LEN_W-1:0]       cnt_m1;
  logic [hdt_pkg::BYTE_IDX_W-1:0]  byte_idx;
  logic [hdt_pkg::TOTAL_WIDTH:0]   total_sum;
  logic                            load;

  assign busy     = cnt_r != '0 || seek_r || endk_r != hdt_pkg::END_NONE;
  assign emit_ok  = !out_valid_r || out_ch.ready;
  assign cnt_m1   = cnt_r - hdt_pkg::LEN_W'(1);
  assign byte_idx = cnt_m1[hdt_pkg::BYTE_IDX_W-1:0];

  // current result item
  always_comb begin
    item_kind  = hdt_pkg::KIND_DATA;
    item_value = 64'(val_r[8*byte_idx +: 8]);
    item_last  = 1'b0;
    if (cnt_r != '0) begin
      item_last = (cnt_r == hdt_pkg::LEN_W'(1)) && (endk_r == hdt_pkg::END_NONE);
    end else if (seek_r) begin
      item_kind  = hdt_pkg::KIND_SEEK;
      item_value = val_r;
      item_last  = endk_r == hdt_pkg::END_NONE;
    end else begin
      item_kind  = (endk_r == hdt_pkg::END_BAD && total_r != '0) ?
                   hdt_pkg::KIND_END_BAD : hdt_pkg::KIND_END_OK;
      item_value = 64'(total_r);
      item_last  = 1'b1;
    end
  end

  // take the next command when the current one is done or leaving now
  assign load      = !empty && (!busy || (emit_ok && item_last));
  assign pop       = load;
  assign total_sum = {1'b0, total_r} + (hdt_pkg::TOTAL_WIDTH + 1)'(head.len);

  // command expansion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      seek_r  <= 1'b0;
      endk_r  <= hdt_pkg::END_NONE;
      total_r <= '0;
    end else if (load) begin
      cnt_r  <= head.len;
      seek_r <= head.seek;
      endk_r <= head.endk;
      if (total_sum[hdt_pkg::TOTAL_WIDTH]) total_r <= '1;
      else total_r <= total_sum[hdt_pkg::TOTAL_WIDTH-1:0];
    end else if (busy && emit_ok) begin
      if (cnt_r != '0) cnt_r <= cnt_m1;
      else if (seek_r) seek_r <= 1'b0;
      else endk_r <= hdt_pkg::END_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) val_r <= head.value;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit_ok) out_valid_r <= busy;
  end

  always_ff @(posedge clk) begin
    if (emit_ok && busy) begin
      out_kind_r  <= item_kind;
      out_value_r <= item_value;
      out_last_r  <= item_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

endmodule

`default_nettype wire

/* sv/hex_dump_text_to_bytes.sv */
// A result item passes the command queue, the back end command registers and the output
// register; later items of the same character follow one per cycle while the output is
// ready. The front end takes one character per cycle while the four-entry command queue
// has room; the back end gives one result item per cycle while the output is ready, and
// a group of n digits gives ceil(n/2) data bytes, at most eight. Synchronous active-low
// reset clears the parser, byte total and queue; the address option resets to off.
// ----------------------------------------------------------------------------
// hex_dump_text_to_bytes: hex dump text parser top level
// Front end parses characters into commands, a queue decouples it from
// the back end that emits data bytes, seeks and the end item.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_dump_text_to_bytes (
  input  wire logic clk,
  input  wire logic rst_n,
  hdt_in_if.sink    in_ch,
  hdt_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);

  hdt_pkg::cmd_t push_cmd;
  hdt_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  // character parser
  hdt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  // command queue
  hdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // result generator
  hdt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
